// ----- src/pcr_pkg.sv -----
// ============================================================================
// pcr_pkg
// Shared types and constants of the polygon corner rounding core.
// ============================================================================
package pcr_pkg;

  localparam int COORD_W        = 32;
  localparam int RAD_W          = 31;
  localparam int CNT_W          = 13;
  localparam int MAX_POINTS_DEF = 4096;
  localparam int IDX_LIMIT      = 8191;

  // Bezier circle handle factor 0.5519 in Q0.16, and the rounding half.
  localparam logic [15:0] TAN_Q16  = 16'd36169;
  localparam logic [47:0] TAN_HALF = 48'd32768;

  typedef struct packed {
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } vtx_t;

  // Request to the point unit: the corner and the neighbor to move toward.
  typedef struct packed {
    vtx_t c;
    vtx_t o;
  } pcr_req_t;

  // Response of the point unit: the moved point and its tangent.
  typedef struct packed {
    vtx_t                      p;
    logic signed [COORD_W-1:0] ty;
    logic signed [COORD_W-1:0] tx;
  } pcr_rsp_t;

endpackage

// ----- src/pcr_point_unit.sv -----
// ============================================================================
// pcr_point_unit
// Computes one rounded point: the corner moved toward a neighbor by
// min(dist/2, radius), plus its tangent. Squares, the square root, the
// scaling products and the divisions all run one bit per cycle.
// ============================================================================
module pcr_point_unit
  import pcr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  pcr_req_t         req_i,
  input  logic [RAD_W-1:0] radius_i,
  output logic             done_o,
  output pcr_rsp_t         rsp_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_SQ, ST_SUM, ST_ROOT, ST_MIN, ST_MUL, ST_DIV, ST_TAN, ST_DONE
  } state_e;

  localparam logic [6:0] MUL_LAST  = 7'd32;
  localparam logic [6:0] ROOT_LAST = 7'd32;
  localparam logic [6:0] DIV_LAST  = 7'd63;

  state_e      state_q;
  logic [6:0]  cnt_q;
  logic        axis_q;

  logic signed [COORD_W-1:0] cx_q, cy_q;
  logic signed [COORD_W:0]   dx_q, dy_q;
  logic [COORD_W:0]          mcand_q, mplier_q;
  logic [65:0]               prod_q;
  logic [63:0]               sx_q;
  logic [65:0]               rad_q;
  logic [33:0]               rem_q;
  logic [32:0]               root_q;
  logic [32:0]               drem_q;
  logic [RAD_W-1:0]          m_q;
  logic signed [COORD_W-1:0] offx_q, offy_q, tx_q, ty_q;

  logic [COORD_W:0] ax, ay;
  logic [33:0]      mul_sum;
  logic [65:0]      mul_next;
  logic [35:0]      root_t;
  logic [34:0]      root_trial;
  logic             root_ge;
  logic [33:0]      div_t;
  logic             div_ge;
  logic [32:0]      div_rem;
  logic [31:0]      half;
  logic [RAD_W-1:0] m_new;
  logic [RAD_W-1:0] quot;
  logic signed [COORD_W-1:0] off_new;
  logic signed [COORD_W-1:0] off_sel;
  logic [COORD_W-1:0] off_mag;
  logic [47:0]      tan_prod;
  logic signed [COORD_W-1:0] tan_new;
  logic             neg_sel;

  // Magnitudes of the two differences.
  assign ax = dx_q[COORD_W] ? (~dx_q + 1'b1) : dx_q;
  assign ay = dy_q[COORD_W] ? (~dy_q + 1'b1) : dy_q;

  // Shift-add multiplier step: one multiplier bit per cycle.
  assign mul_sum  = {1'b0, prod_q[65:33]} + (mplier_q[0] ? {1'b0, mcand_q} : 34'd0);
  assign mul_next = {mul_sum, prod_q[32:1]};

  // Square root step: one result bit per cycle.
  assign root_t     = {rem_q, rad_q[65:64]};
  assign root_trial = {root_q, 2'b01};
  assign root_ge    = root_t >= {1'b0, root_trial};

  // Restoring division step: one quotient bit per cycle.
  assign div_t   = {drem_q, prod_q[63]};
  assign div_ge  = div_t >= {1'b0, root_q};
  assign div_rem = div_ge ? 33'(div_t - {1'b0, root_q}) : div_t[32:0];
  assign quot    = {prod_q[RAD_W-2:0], div_ge};

  // Scale distance: the smaller of half the distance and the radius.
  assign half  = root_q[32:1];
  assign m_new = ({1'b0, radius_i} < half) ? radius_i : half[RAD_W-1:0];

  assign neg_sel = axis_q ? dy_q[COORD_W] : dx_q[COORD_W];
  assign off_new = neg_sel ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

  // Tangent: minus 0.5519 times the offset, rounded on the magnitude.
  assign off_sel  = axis_q ? offy_q : offx_q;
  assign off_mag  = off_sel[COORD_W-1] ? 32'(-off_sel) : off_sel;
  assign tan_prod = {17'd0, off_mag[RAD_W-1:0]} * {32'd0, TAN_Q16} + TAN_HALF;
  assign tan_new  = off_sel[COORD_W-1] ? $signed(tan_prod[47:16])
                                       : -$signed(tan_prod[47:16]);

  // Sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      axis_q  <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (start_i) state_q <= ST_LOAD;
        end
        ST_LOAD: begin
          state_q <= ST_SQ;
          cnt_q   <= '0;
          axis_q  <= 1'b0;
        end
        ST_SQ: begin
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == MUL_LAST) begin
            cnt_q <= '0;
            if (axis_q) begin
              state_q <= ST_SUM;
            end else begin
              axis_q <= 1'b1;
            end
          end
        end
        ST_SUM: begin
          state_q <= ST_ROOT;
          cnt_q   <= '0;
        end
        ST_ROOT: begin
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == ROOT_LAST) state_q <= ST_MIN;
        end
        ST_MIN: begin
          cnt_q  <= '0;
          axis_q <= 1'b0;
          state_q <= (root_q == '0) ? ST_TAN : ST_MUL;
        end
        ST_MUL: begin
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == MUL_LAST) begin
            cnt_q   <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == DIV_LAST) begin
            cnt_q <= '0;
            if (axis_q) begin
              axis_q  <= 1'b0;
              state_q <= ST_TAN;
            end else begin
              axis_q  <= 1'b1;
              state_q <= ST_MUL;
            end
          end
        end
        ST_TAN: begin
          axis_q <= ~axis_q;
          if (axis_q) state_q <= ST_DONE;
        end
        ST_DONE: begin
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cx_q <= req_i.c.x;
          cy_q <= req_i.c.y;
          dx_q <= $signed({req_i.o.x[COORD_W-1], req_i.o.x})
                - $signed({req_i.c.x[COORD_W-1], req_i.c.x});
          dy_q <= $signed({req_i.o.y[COORD_W-1], req_i.o.y})
                - $signed({req_i.c.y[COORD_W-1], req_i.c.y});
        end
      end
      ST_LOAD: begin
        mcand_q  <= ax;
        mplier_q <= ax;
        prod_q   <= '0;
      end
      ST_SQ: begin
        prod_q   <= mul_next;
        mplier_q <= mplier_q >> 1;
        if (cnt_q == MUL_LAST && !axis_q) begin
          sx_q     <= mul_next[63:0];
          mcand_q  <= ay;
          mplier_q <= ay;
          prod_q   <= '0;
        end
      end
      ST_SUM: begin
        rad_q  <= {2'b00, sx_q} + prod_q;
        rem_q  <= '0;
        root_q <= '0;
      end
      ST_ROOT: begin
        rad_q <= {rad_q[63:0], 2'b00};
        if (root_ge) begin
          rem_q  <= 34'(root_t - {1'b0, root_trial});
          root_q <= {root_q[31:0], 1'b1};
        end else begin
          rem_q  <= root_t[33:0];
          root_q <= {root_q[31:0], 1'b0};
        end
      end
      ST_MIN: begin
        m_q      <= m_new;
        mcand_q  <= ax;
        mplier_q <= {2'b00, m_new};
        prod_q   <= '0;
        offx_q   <= '0;
        offy_q   <= '0;
      end
      ST_MUL: begin
        prod_q   <= mul_next;
        mplier_q <= mplier_q >> 1;
        drem_q   <= '0;
      end
      ST_DIV: begin
        drem_q <= div_rem;
        prod_q <= {prod_q[65:64], prod_q[62:0], div_ge};
        if (cnt_q == DIV_LAST) begin
          if (axis_q) begin
            offy_q <= off_new;
          end else begin
            offx_q   <= off_new;
            mcand_q  <= ay;
            mplier_q <= {2'b00, m_q};
            prod_q   <= '0;
          end
        end
      end
      ST_TAN: begin
        if (axis_q) ty_q <= tan_new;
        else        tx_q <= tan_new;
      end
      default: begin
      end
    endcase
  end

  assign done_o  = (state_q == ST_DONE);
  assign rsp_o.p.x = cx_q + offx_q;
  assign rsp_o.p.y = cy_q + offy_q;
  assign rsp_o.tx  = tx_q;
  assign rsp_o.ty  = ty_q;

endmodule

// ----- src/polygon_corner_rounding_core.sv -----
// Flow: an open-path end vertex passes through states ST_NEXT and ST_OUT, waiting for a free
// output; each rounded point is computed in the bit-serial point unit (two 33-step squares,
// a 33-step square root, and two 33-step products each with a 64-step division).
// Vertices are taken one at a time; a vertex yields up to six points.
// The next vertex is taken once the last point is loaded.
// Reset: rst_ni clears the path state, the radius and the output valid at once.
// ============================================================================
// polygon_corner_rounding_core
// Rounds the corners of vertex paths into pairs of Bezier points; open ends pass through.
// ============================================================================
module polygon_corner_rounding_core
  import pcr_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration: corner_radius.
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [RAD_W-1:0]   cfg_data_i,
  // Vertex stream.
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // pos_x, pos_y, tan_in_x, tan_in_y, tan_out_x, tan_out_y
  input  logic [191:0]       s_axis_tdata,
  // path_first, path_closed
  input  logic [1:0]         s_axis_tuser,
  input  logic               s_axis_tlast,
  // Point stream.
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // point_x, point_y, point_in_x, point_in_y, point_out_x, point_out_y,
  // point_index, zero pad
  output logic [207:0]       m_axis_tdata,
  output logic               m_axis_tlast
);

  localparam logic [CNT_W-1:0] VCAP =
    CNT_W'((MAX_POINTS < IDX_LIMIT) ? MAX_POINTS : IDX_LIMIT);

  typedef enum logic [1:0] {ST_IDLE, ST_NEXT, ST_CALC, ST_OUT} state_e;

  state_e           state_q;
  logic [RAD_W-1:0] radius_q;
  logic [CNT_W-1:0] cnt_q;
  logic             closed_q;
  logic [2:0]       cv_q;
  logic             pass_q;
  logic             is_pass_q;
  logic             side_q;
  logic [1:0]       jsel_q;
  logic             m_valid_q;

  vtx_t start_q, second_q, older_q, newer_q;
  vtx_t             cp_q [3];
  vtx_t             cc_q [3];
  vtx_t             cn_q [3];
  logic [CNT_W-1:0] cidx_q [3];
  logic             cfin_q [3];
  vtx_t                      pv_q;
  logic signed [COORD_W-1:0] pinx_q, piny_q, poutx_q, pouty_q;
  logic [CNT_W-1:0]          pidx_q;
  logic                      pfin_q;

  logic signed [COORD_W-1:0] ox_q, oy_q, oinx_q, oiny_q, ooutx_q, oouty_q;
  logic [CNT_W-1:0]          oidx_q;
  logic                      ofin_q;

  logic             in_acc, out_free;
  logic             first_eff, closed_eff, last;
  logic [CNT_W-1:0] k, two_k, cnt_next;
  vtx_t             cur, second_eff;
  logic [1:0]       jnext;
  logic             start;
  pcr_req_t         req;
  pcr_rsp_t         rsp;
  logic             done;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  // Path bookkeeping for the incoming vertex.
  assign cur.x      = s_axis_tdata[31:0];
  assign cur.y      = s_axis_tdata[63:32];
  assign last       = s_axis_tlast;
  assign first_eff  = s_axis_tuser[0] || (cnt_q == '0);
  assign closed_eff = first_eff ? s_axis_tuser[1] : closed_q;
  assign k          = first_eff ? '0 : cnt_q;
  assign two_k      = {k[CNT_W-2:0], 1'b0};
  assign second_eff = (k == CNT_W'(1)) ? cur : second_q;
  assign cnt_next   = last ? '0 : ((k < VCAP) ? k + CNT_W'(1) : k);

  // Earliest pending corner goes first.
  assign jnext = cv_q[0] ? 2'd0 : (cv_q[1] ? 2'd1 : 2'd2);
  assign start = (state_q == ST_NEXT) && (cv_q != '0);
  assign req.c = cc_q[jnext];
  assign req.o = side_q ? cn_q[jnext] : cp_q[jnext];

  pcr_point_unit u_point (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .req_i    (req),
    .radius_i (radius_q),
    .done_o   (done),
    .rsp_o    (rsp)
  );

  // Control state and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      radius_q  <= '0;
      cnt_q     <= '0;
      closed_q  <= 1'b0;
      cv_q      <= '0;
      pass_q    <= 1'b0;
      is_pass_q <= 1'b0;
      side_q    <= 1'b0;
      jsel_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) radius_q <= cfg_data_i;
      if (m_valid_q && m_axis_tready) m_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            closed_q <= closed_eff;
            cnt_q    <= cnt_next;
            cv_q     <= {closed_eff && last && (k != '0), closed_eff && last, k >= CNT_W'(2)};
            pass_q   <= !closed_eff && ((k == '0) || last);
            side_q   <= 1'b0;
            state_q  <= ST_NEXT;
          end
        end
        ST_NEXT: begin
          if (cv_q != '0) begin
            jsel_q    <= jnext;
            is_pass_q <= 1'b0;
            state_q   <= ST_CALC;
          end else if (pass_q) begin
            is_pass_q <= 1'b1;
            state_q   <= ST_OUT;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_CALC: begin
          if (done) state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            state_q   <= ST_NEXT;
            if (is_pass_q) begin
              pass_q <= 1'b0;
            end else begin
              side_q <= ~side_q;
              if (side_q) cv_q[jsel_q] <= 1'b0;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Vertex history and pending corners.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (k == '0)       start_q  <= cur;
      if (k == CNT_W'(1)) second_q <= cur;
      older_q <= newer_q;
      newer_q <= cur;
      cp_q[0]   <= older_q;
      cc_q[0]   <= newer_q;
      cn_q[0]   <= cur;
      cidx_q[0] <= closed_eff ? two_k - CNT_W'(2) : two_k - CNT_W'(3);
      cfin_q[0] <= 1'b0;
      if (k == '0) begin
        cp_q[1]   <= cur;
        cc_q[1]   <= cur;
        cn_q[1]   <= cur;
        cidx_q[1] <= '0;
        cfin_q[1] <= 1'b1;
      end else begin
        cp_q[1]   <= newer_q;
        cc_q[1]   <= cur;
        cn_q[1]   <= start_q;
        cidx_q[1] <= two_k;
        cfin_q[1] <= 1'b0;
      end
      cp_q[2]   <= cur;
      cc_q[2]   <= start_q;
      cn_q[2]   <= second_eff;
      cidx_q[2] <= '0;
      cfin_q[2] <= 1'b1;
      pv_q    <= cur;
      pinx_q  <= s_axis_tdata[95:64];
      piny_q  <= s_axis_tdata[127:96];
      poutx_q <= s_axis_tdata[159:128];
      pouty_q <= s_axis_tdata[191:160];
      pidx_q  <= (k == '0) ? '0 : two_k - CNT_W'(1);
      pfin_q  <= last;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && out_free) begin
      if (is_pass_q) begin
        ox_q    <= pv_q.x;
        oy_q    <= pv_q.y;
        oinx_q  <= pinx_q;
        oiny_q  <= piny_q;
        ooutx_q <= poutx_q;
        oouty_q <= pouty_q;
        oidx_q  <= pidx_q;
        ofin_q  <= pfin_q;
      end else if (!side_q) begin
        ox_q    <= rsp.p.x;
        oy_q    <= rsp.p.y;
        oinx_q  <= '0;
        oiny_q  <= '0;
        ooutx_q <= rsp.tx;
        oouty_q <= rsp.ty;
        oidx_q  <= cidx_q[jsel_q];
        ofin_q  <= 1'b0;
      end else begin
        ox_q    <= rsp.p.x;
        oy_q    <= rsp.p.y;
        oinx_q  <= rsp.tx;
        oiny_q  <= rsp.ty;
        ooutx_q <= '0;
        oouty_q <= '0;
        oidx_q  <= cidx_q[jsel_q] + CNT_W'(1);
        ofin_q  <= cfin_q[jsel_q];
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {3'b000, oidx_q, oouty_q, ooutx_q, oiny_q, oinx_q, oy_q, ox_q};
  assign m_axis_tlast  = ofin_q;

endmodule

// ----- src/pcr_checker.sv -----
// ============================================================================
// pcr_checker
// Port-level checks of the polygon corner rounding core.
// ============================================================================
module pcr_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         cfg_valid_i,
  input logic         cfg_ready_o,
  input logic [30:0]  cfg_data_i,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [191:0] s_axis_tdata,
  input logic [1:0]   s_axis_tuser,
  input logic         s_axis_tlast,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [207:0] m_axis_tdata,
  input logic         m_axis_tlast
);

  // A stalled point holds its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("stalled point changed");

  // After a vertex transaction the core is busy with it.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("vertex taken while busy");

  // A new point only appears while a vertex is in work.
  a_point_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("point without a vertex in work");

  // The pad bits of the point stream stay zero.
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[207:205] == 3'b000)
    else $error("point pad bits set");

endmodule

bind polygon_corner_rounding_core pcr_checker u_pcr_checker (.*);

// ----- bench/polygon_corner_rounding_core_test.sv -----
`timescale 1ns / 100ps
// ============================================================================
// polygon_corner_rounding_core_test
// Self-checking bench for the corner rounding core. A directed stimulus table
// covers the pass-through ends, single-vertex paths, coincident vertices and
// extreme coordinates. It runs under the reset radius and under the largest
// radius. Random open, closed and broken paths follow in phases with different
// radius settings and idle patterns. Every point is compared field by field
// against a bit-exact predictor, or against a row's own literal point.
// ============================================================================
module polygon_corner_rounding_core_test;
  import pcr_pkg::*;

  localparam int VERTEX_CAP   = (MAX_POINTS_DEF < IDX_LIMIT) ? MAX_POINTS_DEF : IDX_LIMIT;
  localparam int DRAIN_CYCLES = 2000;
  localparam int SETTLE_GAP   = 600;
  localparam int HOLD_CYCLES  = 3000;
  localparam int STALL_LIMIT  = 20000;

  // One output point of the core.
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] in_x;
    logic [31:0] in_y;
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [12:0] index;
    logic        final_pt;
  } point_t;

  // One row of the directed stimulus table.
  typedef struct {
    logic [31:0] x, y, tix, tiy, tox, toy;
    logic        first, last, closed;
    logic        has_lit;
    point_t      lit;
  } vtx_row_t;

  logic           clk_i;
  logic           rst_ni;
  logic           cfg_valid_i;
  logic           cfg_ready_o;
  logic [RAD_W-1:0] cfg_data_i;
  logic           s_axis_tvalid;
  logic           s_axis_tready;
  // pos_x, pos_y, tan_in_x, tan_in_y, tan_out_x, tan_out_y
  logic [191:0]   s_axis_tdata;
  // path_first, path_closed
  logic [1:0]     s_axis_tuser;
  logic           s_axis_tlast;
  logic           m_axis_tvalid;
  logic           m_axis_tready;
  // point_x, point_y, point_in_x, point_in_y, point_out_x, point_out_y,
  // point_index, zero pad
  logic [207:0]   m_axis_tdata;
  logic           m_axis_tlast;

  polygon_corner_rounding_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // Predictor state.
  logic [30:0] radius_q;
  longint      start_x, start_y, second_x, second_y;
  longint      older_x, older_y, newer_x, newer_y;
  int          vertex_cnt;
  logic        closed_q;

  point_t      expected_points[$];
  point_t      step_points[$];
  int          error_count;
  int          vertex_count_total;
  int          point_count_total;
  int          path_count_total;
  int          idle_pct_snd;
  int          stall_pct_rcv;
  int          hold_left;
  int          hold_req_cnt;
  int          hold_ack_cnt;
  int          quiet_cycles;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Floor square root of a 68-bit value, two bits per step.
  function automatic logic [33:0] floor_sqrt(logic [67:0] v);
    logic [69:0] rem;
    logic [69:0] res;
    logic [69:0] trial;
    rem = '0;
    res = '0;
    for (int p = 33; p >= 0; p--) begin
      rem   = (rem << 2) | v[2*p +: 2];
      trial = (res << 2) | 70'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        res = (res << 1) | 70'd1;
      end else begin
        res = res << 1;
      end
    end
    return res[33:0];
  endfunction

  function automatic longint scaled_offset(longint d, logic [63:0] m, logic [63:0] span);
    logic [127:0] a;
    logic [127:0] q;
    a = (d < 0) ? 128'(-d) : 128'(d);
    q = (a * 128'(m)) / 128'(span);
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint handle_of(longint off);
    logic [127:0] a;
    longint t;
    a = (off < 0) ? 128'(-off) : 128'(off);
    t = longint'((a * 128'(TAN_Q16) + 128'(TAN_HALF)) >> 16);
    return (off < 0) ? t : -t;
  endfunction

  // Point near corner (cx,cy) moved toward neighbor (ox,oy), and its handle.
  task automatic move_toward(input longint cx, cy, ox, oy,
                             output longint vx, vy, tx, ty);
    longint      dx, dy, offx, offy;
    logic [67:0] ax, ay;
    logic [63:0] span, m;
    dx = ox - cx;
    dy = oy - cy;
    ax = (dx < 0) ? 68'(-dx) : 68'(dx);
    ay = (dy < 0) ? 68'(-dy) : 68'(dy);
    span = 64'(floor_sqrt(ax * ax + ay * ay));
    offx = 0;
    offy = 0;
    if (span != 0) begin
      m = span >> 1;
      if (64'(radius_q) < m) m = 64'(radius_q);
      offx = scaled_offset(dx, m, span);
      offy = scaled_offset(dy, m, span);
    end
    vx = cx + offx;
    vy = cy + offy;
    tx = handle_of(offx);
    ty = handle_of(offy);
  endtask

  function automatic point_t make_point(longint x, y, ix, iy, ox, oy, int idx, logic fin);
    point_t p;
    p.x = x[31:0];
    p.y = y[31:0];
    p.in_x = ix[31:0];
    p.in_y = iy[31:0];
    p.out_x = ox[31:0];
    p.out_y = oy[31:0];
    p.index = idx[12:0];
    p.final_pt = fin;
    return p;
  endfunction

  // A rounded corner: one point toward the previous vertex, one toward the next.
  task automatic round_corner(input longint prx, pry, cx, cy, nx, ny,
                              input int idx, input logic fin);
    longint vx, vy, tx, ty;
    move_toward(cx, cy, prx, pry, vx, vy, tx, ty);
    step_points.insert(step_points.size(), make_point(vx, vy, 0, 0, tx, ty, idx, 1'b0));
    move_toward(cx, cy, nx, ny, vx, vy, tx, ty);
    step_points.insert(step_points.size(), make_point(vx, vy, tx, ty, 0, 0, idx + 1, fin));
  endtask

  // Works out the points caused by one accepted vertex into step_points.
  task automatic predict_vertex(input logic [191:0] d, input logic first, last, closed);
    longint x, y;
    int     k;
    x = longint'($signed(d[31:0]));
    y = longint'($signed(d[63:32]));
    step_points.delete();
    if (first || vertex_cnt == 0) begin
      vertex_cnt = 0;
      closed_q = closed;
      path_count_total++;
    end
    k = vertex_cnt;
    if (!closed_q) begin
      if (k == 0) begin
        step_points.insert(step_points.size(),
                           make_point(x, y, $signed(d[95:64]), $signed(d[127:96]),
                                      $signed(d[159:128]), $signed(d[191:160]), 0, last));
        start_x = x;
        start_y = y;
      end else begin
        if (k >= 2)
          round_corner(older_x, older_y, newer_x, newer_y, x, y, 2 * (k - 1) - 1, 1'b0);
        if (last)
          step_points.insert(step_points.size(),
                             make_point(x, y, $signed(d[95:64]), $signed(d[127:96]),
                                        $signed(d[159:128]), $signed(d[191:160]),
                                        2 * k - 1, 1'b1));
      end
    end else begin
      if (k == 0) begin
        start_x = x;
        start_y = y;
      end
      if (k == 1) begin
        second_x = x;
        second_y = y;
      end
      if (k >= 2)
        round_corner(older_x, older_y, newer_x, newer_y, x, y, 2 * (k - 1), 1'b0);
      if (last) begin
        if (k == 0) begin
          round_corner(x, y, x, y, x, y, 0, 1'b1);
        end else begin
          round_corner(newer_x, newer_y, x, y, start_x, start_y, 2 * k, 1'b0);
          round_corner(x, y, start_x, start_y, second_x, second_y, 0, 1'b1);
        end
      end
    end
    older_x = newer_x;
    older_y = newer_y;
    newer_x = x;
    newer_y = y;
    if (last) vertex_cnt = 0;
    else if (vertex_cnt < VERTEX_CAP) vertex_cnt++;
  endtask

  // Offers one vertex, with random idle cycles ahead of it; predicts on acceptance.
  task automatic send_vertex(input logic [191:0] d, input logic first, last, closed,
                             input logic has_lit, input point_t lit);
    while ($urandom_range(99) < idle_pct_snd) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= {closed, first};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    vertex_count_total++;
    predict_vertex(d, first, last, closed);
    if (has_lit) expected_points.insert(expected_points.size(), lit);
    else foreach (step_points[i]) expected_points.insert(expected_points.size(), step_points[i]);
  endtask

  task automatic wait_for_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (SETTLE_GAP) @(posedge clk_i);
  endtask

  task automatic write_radius(input logic [30:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    radius_q = value;
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] got, exp_v);
    $display("mismatch on point %0d, %s: got %h, expected %h",
             point_count_total, field, got, exp_v);
    error_count++;
  endtask

  // Random paths: mostly well-formed, some with noise flags or missing ends.
  task automatic run_random_paths(input int n_items);
    int          sent, len;
    logic        closed, first, last, wide;
    logic [191:0] d;
    point_t      none;
    none = '0;
    sent = 0;
    while (sent < n_items) begin
      len    = ($urandom_range(9) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 7);
      closed = 1'($urandom_range(1));
      wide   = ($urandom_range(5) == 0);
      for (int i = 0; i < len; i++) begin
        for (int w = 0; w < 6; w++) d[32*w +: 32] = $urandom;
        if (!wide) begin
          d[31:0]  = 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
          d[63:32] = 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
          if ($urandom_range(15) == 0) d[63:32] = d[31:0];
        end
        first = (i == 0) ? ($urandom_range(19) != 0) : ($urandom_range(29) == 0);
        last  = (i == len - 1) ? ($urandom_range(19) != 0) : 1'b0;
        send_vertex(d, first, last, (i == 0) ? closed : logic'($urandom_range(1)),
                    1'b0, none);
        sent++;
      end
    end
  endtask

  // Receiver: random stalls, and a long hold-off when requested.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left     <= 0;
      hold_ack_cnt  <= 0;
    end else if (hold_ack_cnt != hold_req_cnt) begin
      m_axis_tready <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      hold_ack_cnt  <= hold_req_cnt;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct_rcv);
    end
  end

  // Point checker.
  always @(posedge clk_i) begin
    point_t got, exp_p;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.x        = m_axis_tdata[31:0];
      got.y        = m_axis_tdata[63:32];
      got.in_x     = m_axis_tdata[95:64];
      got.in_y     = m_axis_tdata[127:96];
      got.out_x    = m_axis_tdata[159:128];
      got.out_y    = m_axis_tdata[191:160];
      got.index    = m_axis_tdata[204:192];
      got.final_pt = m_axis_tlast;
      if (expected_points.size() == 0) begin
        $display("unexpected point: index %0d x %h y %h", got.index, got.x, got.y);
        error_count++;
      end else begin
        exp_p = expected_points.pop_front();
        if (got.x != exp_p.x) report_mismatch("point_x", got.x, exp_p.x);
        if (got.y != exp_p.y) report_mismatch("point_y", got.y, exp_p.y);
        if (got.in_x != exp_p.in_x) report_mismatch("point_in_x", got.in_x, exp_p.in_x);
        if (got.in_y != exp_p.in_y) report_mismatch("point_in_y", got.in_y, exp_p.in_y);
        if (got.out_x != exp_p.out_x) report_mismatch("point_out_x", got.out_x, exp_p.out_x);
        if (got.out_y != exp_p.out_y) report_mismatch("point_out_y", got.out_y, exp_p.out_y);
        if (got.index != exp_p.index)
          report_mismatch("point_index", 32'(got.index), 32'(exp_p.index));
        if (got.final_pt != exp_p.final_pt)
          report_mismatch("point_final", 32'(got.final_pt), 32'(exp_p.final_pt));
      end
      point_count_total++;
    end
  end

  // Watchdog: ends the run after too many cycles without any transaction.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("polygon_corner_rounding_core regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus.
  initial begin
    vtx_row_t    rows[$];
    vtx_row_t    r;
    logic [191:0] d;
    logic [30:0] radii[4];
    int          idle_snd[4];
    int          stall_rcv[4];

    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    s_axis_tlast = 1'b0;
    error_count = 0;
    vertex_count_total = 0;
    point_count_total = 0;
    path_count_total = 0;
    idle_pct_snd = 0;
    stall_pct_rcv = 0;
    hold_req_cnt = 0;
    radius_q = '0;
    start_x = 0; start_y = 0; second_x = 0; second_y = 0;
    older_x = 0; older_y = 0; newer_x = 0; newer_y = 0;
    vertex_cnt = 0;
    closed_q = 1'b0;

    // Directed table. Open single vertices pass through unchanged.
    r = '{default: '0};
    r.x = 32'h8000_0000; r.y = 32'h7fff_ffff; r.tix = 32'h7fff_ffff; r.tiy = 32'h8000_0000;
    r.tox = 32'hffff_ffff; r.toy = 32'h0000_0001; r.first = 1; r.last = 1; r.has_lit = 1;
    r.lit = '{r.x, r.y, r.tix, r.tiy, r.tox, r.toy, 13'd0, 1'b1};
    rows.insert(rows.size(), r);
    r.x = 32'h7fff_ffff; r.y = 32'h8000_0000; r.tix = 32'h0; r.tiy = 32'hffff_ffff;
    r.tox = 32'h8000_0000; r.toy = 32'h7fff_ffff;
    r.lit = '{r.x, r.y, r.tix, r.tiy, r.tox, r.toy, 13'd0, 1'b1};
    rows.insert(rows.size(), r);
    // A vertex while no path is open starts one, with path_first low.
    r.first = 0; r.x = 32'h0001_2000; r.y = 32'hfffe_0000;
    r.lit = '{r.x, r.y, r.tix, r.tiy, r.tox, r.toy, 13'd0, 1'b1};
    rows.insert(rows.size(), r);
    r = '{default: '0};
    // Closed single vertex: two copies with zero handles.
    r.x = 32'h0003_0000; r.y = 32'h0004_0000; r.first = 1; r.last = 1; r.closed = 1;
    rows.insert(rows.size(), r);
    // Open triangle.
    r = '{default: '0}; r.first = 1; r.tix = 32'h1234; r.toy = 32'hffff_0000;
    rows.insert(rows.size(), r);
    r = '{default: '0}; r.x = 32'h000a_0000;
    rows.insert(rows.size(), r);
    r = '{default: '0}; r.x = 32'h000a_0000; r.y = 32'h0006_0000; r.last = 1; r.tox = 32'h55;
    rows.insert(rows.size(), r);
    // Closed square.
    r = '{default: '0}; r.first = 1; r.closed = 1;
    rows.insert(rows.size(), r);
    r = '{default: '0}; r.x = 32'h0010_0000; r.closed = 1;
    rows.insert(rows.size(), r);
    r = '{default: '0}; r.x = 32'h0010_0000; r.y = 32'h0010_0000;
    rows.insert(rows.size(), r);
    r = '{default: '0}; r.y = 32'h0010_0000; r.last = 1;
    rows.insert(rows.size(), r);
    // Closed path of coincident vertices.
    r = '{default: '0}; r.x = 32'hffff_f000; r.y = 32'h0000_1000; r.first = 1; r.closed = 1;
    rows.insert(rows.size(), r);
    r.first = 0;
    rows.insert(rows.size(), r);
    r.last = 1;
    rows.insert(rows.size(), r);
    // Open path across the full coordinate range.
    r = '{default: '0}; r.x = 32'h8000_0000; r.y = 32'h8000_0000; r.first = 1;
    rows.insert(rows.size(), r);
    r = '{default: '0}; r.x = 32'h7fff_ffff; r.y = 32'h7fff_ffff;
    rows.insert(rows.size(), r);
    r = '{default: '0}; r.x = 32'h8000_0000; r.y = 32'h7fff_ffff;
    rows.insert(rows.size(), r);
    r = '{default: '0}; r.x = 32'h7fff_ffff; r.y = 32'h8000_0000; r.last = 1;
    rows.insert(rows.size(), r);
    // Closed path across the full range, two vertices.
    r = '{default: '0}; r.x = 32'h8000_0000; r.y = 32'h7fff_ffff; r.first = 1; r.closed = 1;
    rows.insert(rows.size(), r);
    r = '{default: '0}; r.x = 32'h7fff_ffff; r.y = 32'h8000_0000; r.last = 1;
    rows.insert(rows.size(), r);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The table under the reset radius, then under the largest radius.
    for (int pass = 0; pass < 2; pass++) begin
      if (pass == 1) write_radius(31'h7fff_ffff);
      foreach (rows[i]) begin
        d = {rows[i].toy, rows[i].tox, rows[i].tiy, rows[i].tix, rows[i].y, rows[i].x};
        send_vertex(d, rows[i].first, rows[i].last, rows[i].closed,
                    rows[i].has_lit, rows[i].lit);
      end
      wait_for_idle();
    end

    // Random phases: no idling with a long receiver hold-off, sender idle,
    // receiver stalling, both idling now and then.
    radii = '{31'h0000_4000, 31'h7fff_ffff, 31'd0, 31'($urandom_range(1, 1 << 20))};
    idle_snd = '{0, 87, 0, 8};
    stall_rcv = '{0, 0, 87, 8};
    for (int ph = 0; ph < 4; ph++) begin
      write_radius(radii[ph]);
      idle_pct_snd = idle_snd[ph];
      stall_pct_rcv = stall_rcv[ph];
      if (ph == 0) hold_req_cnt++;
      run_random_paths(80);
      wait_for_idle();
    end
    idle_pct_snd = 0;
    stall_pct_rcv = 0;

    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d vertices in %0d paths, %0d points checked",
             vertex_count_total, path_count_total, point_count_total);
    $display("radius settings: reset value, extremes and mid values; four idle patterns");
    if (error_count == 0 && expected_points.size() == 0) begin
      $display("polygon_corner_rounding_core regression: pass");
    end else begin
      $display("polygon_corner_rounding_core regression: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/pcr_pkg.sv
src/pcr_point_unit.sv
src/polygon_corner_rounding_core.sv
src/pcr_checker.sv
bench/polygon_corner_rounding_core_test.sv
